### hw/rtl/rict_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rict_pkg: shared types and codes for the ranked interval claim table
// Operation and status codes, plus the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rict_pkg;

	localparam logic [3:0] OP_CLAIM      = 4'd0;
	localparam logic [3:0] OP_REL_RES    = 4'd1;
	localparam logic [3:0] OP_REL_ALL    = 4'd2;
	localparam logic [3:0] OP_REL_RSV    = 4'd3;
	localparam logic [3:0] OP_REL_AGT_GL = 4'd4;
	localparam logic [3:0] OP_REL_ALL_GL = 4'd5;
	localparam logic [3:0] OP_HELD       = 4'd6;
	localparam logic [3:0] OP_LENGTH     = 4'd7;
	localparam logic [3:0] OP_CLEAR      = 4'd8;

	localparam logic [2:0] ST_GRANTED = 3'd0;
	localparam logic [2:0] ST_HELD    = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_NOTICE  = 3'd3;
	localparam logic [2:0] ST_RELEASE = 3'd4;
	localparam logic [2:0] ST_ANSWER  = 3'd5;

	localparam logic [1:0] KIND_EDGE = 2'd0;
	localparam logic [1:0] KIND_NODE = 2'd1;

	// result select: final result or eviction notice
	localparam logic [1:0] SEL_FINAL  = 2'd0;
	localparam logic [1:0] SEL_NOTICE = 2'd1;

	localparam int LEN_BITS = 30;
	localparam int CNT_BITS = 7;

	// controller to datapath
	typedef struct packed {
		logic start;     // latch item, clear scan accumulators
		logic scan;      // examine current slot
		logic write_own; // write claim entry
		logic evict;     // drop current slot if marked
		logic rd_next;   // advance the read pointer
		logic rd_zero;   // restart the read pointer
	} rict_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;  // current slot is the final one
		logic blocked;    // a blocker has been seen
		logic hit_mark;   // current slot is marked for eviction
		logic own_found;  // an own or free slot is known
	} rict_sts_t;

endpackage

### hw/rtl/rict_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rict_if: valid/ready channel
// Carries one item per transfer; payload type set by the instance.
// ----------------------------------------------------------------------------
interface rict_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/rict_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rict_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module rict_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or read the addressed word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

### hw/rtl/rict_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rict_ctrl: sequencer for the claim table
// Steps each item through a scan and, for a granted claim, a write and an
// eviction pass, then hands one result at a time to the output register.
// ----------------------------------------------------------------------------
module rict_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [3:0]           in_op,
	output logic                 in_ready,
	input  logic                 out_free,
	output logic                 out_load,
	output logic [1:0]           out_sel,
	output rict_pkg::rict_cmd_t  cmd,
	input  rict_pkg::rict_sts_t  sts
);
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PRIME  = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_WRITE  = 3'd3;
	localparam logic [2:0] S_EVICT  = 3'd4;
	localparam logic [2:0] S_FINAL  = 3'd5;
	localparam logic [2:0] S_EPRIME = 3'd6;

	logic [2:0] state_q, state_d;
	logic       known_op;
	logic       is_claim_q;

	assign known_op = in_op <= rict_pkg::OP_CLEAR;
	assign in_ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			is_claim_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				is_claim_q <= in_op == rict_pkg::OP_CLAIM;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		out_load = 1'b0;
		out_sel  = rict_pkg::SEL_FINAL;
		case (state_q)
			S_IDLE: begin
				cmd.rd_zero = 1'b1;
				if (in_valid && known_op) begin
					cmd.start = 1'b1;
					state_d   = S_PRIME;
				end
			end
			S_PRIME: begin
				cmd.rd_next = 1'b1;
				state_d     = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan    = 1'b1;
				cmd.rd_next = 1'b1;
				if (sts.scan_last) begin
					state_d = is_claim_q ? S_WRITE : S_FINAL;
				end
			end
			S_WRITE: begin
				cmd.rd_zero = 1'b1;
				if (sts.blocked || !sts.own_found) begin
					state_d = S_FINAL;
				end else begin
					cmd.write_own = 1'b1;
					state_d       = S_EPRIME;
				end
			end
			S_EPRIME: begin
				// fetch slot 0 ahead of the eviction pass
				cmd.rd_next = 1'b1;
				state_d     = S_EVICT;
			end
			S_EVICT: begin
				// one slot per cycle; stall on a notice until the output is free
				if (!sts.hit_mark || out_free) begin
					cmd.evict   = 1'b1;
					cmd.rd_next = 1'b1;
					if (sts.hit_mark) begin
						out_load = 1'b1;
						out_sel  = rict_pkg::SEL_NOTICE;
					end
					if (sts.scan_last) begin
						state_d = S_FINAL;
					end
				end
			end
			S_FINAL: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

### hw/rtl/rict_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rict_dpath: claim table storage and scan datapath
// Entry fields live in a RAM, valid and eviction marks in flip-flops; one
// slot is examined per cycle and the scan accumulators build the answer.
// ----------------------------------------------------------------------------
module rict_dpath #(
	parameter int MAX_CLAIMS = 64,
	parameter int AGENT_BITS = 16,
	parameter int INDEX_BITS = 16,
	parameter int POS_BITS   = 24,
	parameter int RANK_BITS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [3:0]            in_op,
	input  logic [AGENT_BITS-1:0] in_agent,
	input  logic [1:0]            in_kind,
	input  logic [INDEX_BITS-1:0] in_index,
	input  logic [POS_BITS-1:0]   in_from,
	input  logic [POS_BITS-1:0]   in_to,
	input  logic                  in_occ,
	input  logic [RANK_BITS-1:0]  in_rank,
	input  rict_pkg::rict_cmd_t   cmd,
	output rict_pkg::rict_sts_t   sts,
	input  logic [1:0]            out_sel,
	output logic [2:0]            res_status,
	output logic [AGENT_BITS-1:0] res_other,
	output logic                  res_found,
	output logic [rict_pkg::LEN_BITS-1:0] res_len,
	output logic [rict_pkg::CNT_BITS-1:0] res_removed,
	output logic                  res_last
);
	localparam int AW = $clog2(MAX_CLAIMS);
	localparam int EW = AGENT_BITS + 2 + INDEX_BITS + 2 * POS_BITS + 1 + RANK_BITS;
	localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_CLAIMS - 1);

	// latched item
	logic [3:0]            op_q;
	logic [AGENT_BITS-1:0] agent_q;
	logic [1:0]            kind_q;
	logic [INDEX_BITS-1:0] index_q;
	logic [POS_BITS-1:0]   from_q, to_q;
	logic                  occ_q;
	logic [RANK_BITS-1:0]  rank_q;

	// slot pointers: rd_q is the address, cur_q the slot whose data is out
	logic [AW-1:0] rd_q, cur_q;
	logic [MAX_CLAIMS-1:0] valid_q, mark_q;

	// accumulators
	logic                  blocked_q, own_ok_q, free_ok_q, found_q;
	logic [AW-1:0]         own_q, free_q;
	logic [AGENT_BITS-1:0] other_q;
	logic [rict_pkg::LEN_BITS-1:0] sum_q;
	logic [rict_pkg::LEN_BITS:0]   sum_add;
	logic [rict_pkg::CNT_BITS-1:0] removed_q;

	// RAM
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	logic [AGENT_BITS-1:0] e_agent;
	logic [1:0]            e_kind;
	logic [INDEX_BITS-1:0] e_res;
	logic [POS_BITS-1:0]   e_start, e_end;
	logic                  e_occ;
	logic [RANK_BITS-1:0]  e_rank;

	assign {e_agent, e_kind, e_res, e_start, e_end, e_occ, e_rank} = ram_rdata;

	// hold the current slot on the address while the pointer does not move
	assign ram_we    = cmd.write_own;
	assign ram_addr  = cmd.write_own ? (own_ok_q ? own_q : free_q)
		: ((cmd.rd_next || cmd.rd_zero) ? rd_q : cur_q);
	assign ram_wdata = {agent_q, kind_q, index_q, from_q, to_q, occ_q, rank_q};

	rict_ram #(.WIDTH(EW), .DEPTH(MAX_CLAIMS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// slot compare
	logic e_valid, same_res, same_agent, overlap, conflict, refuse, rel_hit, guide;
	logic len_hit;
	logic [POS_BITS-1:0] e_len;

	always_comb begin
		e_valid    = valid_q[cur_q];
		same_res   = e_kind == kind_q && e_res == index_q;
		same_agent = e_agent == agent_q;
		overlap    = from_q < e_end && e_start < to_q;
		conflict   = kind_q != rict_pkg::KIND_EDGE || overlap;
		refuse     = e_occ || (!occ_q && e_rank >= rank_q);
		guide      = e_kind == rict_pkg::KIND_EDGE || e_kind == rict_pkg::KIND_NODE;
		case (op_q)
			rict_pkg::OP_REL_RES:    rel_hit = same_agent && same_res;
			rict_pkg::OP_REL_ALL:    rel_hit = same_agent;
			rict_pkg::OP_REL_RSV:    rel_hit = same_agent && !e_occ;
			rict_pkg::OP_REL_AGT_GL: rel_hit = same_agent && guide;
			rict_pkg::OP_REL_ALL_GL: rel_hit = guide;
			rict_pkg::OP_CLEAR:      rel_hit = 1'b1;
			default:                 rel_hit = 1'b0;
		endcase
		len_hit = e_kind == rict_pkg::KIND_EDGE && e_res == index_q && !same_agent
			&& e_end > e_start;
		e_len   = e_end - e_start;
		sum_add = {1'b0, sum_q} + (rict_pkg::LEN_BITS + 1)'(e_len);
	end

	assign sts.scan_last = cur_q == LAST_SLOT;
	assign sts.blocked   = blocked_q;
	assign sts.hit_mark  = mark_q[cur_q];
	assign sts.own_found = own_ok_q || free_ok_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q    <= in_op;
			agent_q <= in_agent;
			kind_q  <= in_kind;
			index_q <= in_index;
			from_q  <= in_from;
			to_q    <= in_to;
			occ_q   <= in_occ;
			rank_q  <= in_rank;
		end
	end

	// pointers, table flags and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q      <= '0;
			cur_q     <= '0;
			valid_q   <= '0;
			mark_q    <= '0;
			blocked_q <= 1'b0;
			own_ok_q  <= 1'b0;
			free_ok_q <= 1'b0;
			found_q   <= 1'b0;
			own_q     <= '0;
			free_q    <= '0;
			other_q   <= '0;
			sum_q     <= '0;
			removed_q <= '0;
		end else begin
			if (cmd.rd_zero) begin
				rd_q <= '0;
			end else if (cmd.rd_next) begin
				rd_q <= rd_q + AW'(1);
			end
			cur_q <= ram_addr;
			if (cmd.start) begin
				mark_q    <= '0;
				blocked_q <= 1'b0;
				own_ok_q  <= 1'b0;
				free_ok_q <= 1'b0;
				found_q   <= 1'b0;
				other_q   <= '0;
				sum_q     <= '0;
				removed_q <= '0;
			end
			if (cmd.scan) begin
				if (!e_valid && !free_ok_q) begin
					free_ok_q <= 1'b1;
					free_q    <= cur_q;
				end
				if (op_q == rict_pkg::OP_CLAIM) begin
					if (e_valid && same_res && !blocked_q) begin
						if (same_agent) begin
							if (!own_ok_q) begin
								own_ok_q <= 1'b1;
								own_q    <= cur_q;
							end
						end else if (conflict) begin
							if (refuse) begin
								blocked_q <= 1'b1;
								other_q   <= e_agent;
							end else begin
								mark_q[cur_q] <= 1'b1;
							end
						end
					end
				end else if (op_q == rict_pkg::OP_HELD) begin
					if (e_valid && same_res && !same_agent && !found_q) begin
						found_q <= 1'b1;
						other_q <= e_agent;
					end
				end else if (op_q == rict_pkg::OP_LENGTH) begin
					// add and saturate the running sum
					if (e_valid && len_hit) begin
						sum_q <= sum_add[rict_pkg::LEN_BITS] ? '1
							: sum_add[rict_pkg::LEN_BITS-1:0];
					end
				end else if (e_valid && rel_hit) begin
					valid_q[cur_q] <= 1'b0;
					removed_q      <= removed_q + rict_pkg::CNT_BITS'(1);
				end
			end
			if (cmd.write_own) begin
				valid_q[own_ok_q ? own_q : free_q] <= 1'b1;
			end
			if (cmd.evict && mark_q[cur_q]) begin
				valid_q[cur_q] <= 1'b0;
			end
		end
	end

	// result word
	always_comb begin
		res_status  = rict_pkg::ST_GRANTED;
		res_other   = '0;
		res_found   = 1'b0;
		res_len     = '0;
		res_removed = '0;
		res_last    = 1'b1;
		if (out_sel == rict_pkg::SEL_NOTICE) begin
			res_status = rict_pkg::ST_NOTICE;
			res_other  = e_agent;
			res_last   = 1'b0;
		end else begin
			case (op_q)
				rict_pkg::OP_CLAIM: begin
					if (blocked_q) begin
						res_status = rict_pkg::ST_HELD;
						res_other  = other_q;
					end else if (!own_ok_q && !free_ok_q) begin
						res_status = rict_pkg::ST_FULL;
					end
				end
				rict_pkg::OP_HELD: begin
					res_status = rict_pkg::ST_ANSWER;
					res_other  = other_q;
					res_found  = found_q;
				end
				rict_pkg::OP_LENGTH: begin
					res_status = rict_pkg::ST_ANSWER;
					res_len    = sum_q;
				end
				default: begin
					res_status  = rict_pkg::ST_RELEASE;
					res_removed = removed_q;
				end
			endcase
		end
	end
endmodule

### hw/rtl/ranked_interval_claim_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ranked_interval_claim_table_unit: ranked interval claim table
// Top level joining the sequencer, the table datapath and the output register.
// ----------------------------------------------------------------------------
// Usage:
// req carries one operation per transfer (claim, releases, held query, length
// query, clear). rsp returns its results: for a claim zero or more preempted
// notices (last low) then one final result (last high); every other known
// operation gives one result. Operation codes above clear give no result.
// Each item is handled alone: a scan reads one table slot per cycle from the
// entry RAM over all MAX_CLAIMS slots; a granted claim then adds a write and
// an eviction pass over the table. req is ready only between items, so a new
// item is taken only once the previous one has loaded its final result.
// Reset empties the table at once through per-slot valid flops; no clearing
// pass is needed. A stall on rsp holds the current result in the output
// register and pauses the eviction pass; nothing is dropped.
// ----------------------------------------------------------------------------
module ranked_interval_claim_table_unit #(
	parameter int MAX_CLAIMS = 64,
	parameter int AGENT_BITS = 16,
	parameter int INDEX_BITS = 16,
	parameter int POS_BITS   = 24,
	parameter int RANK_BITS  = 8
) (
	input logic clk,
	input logic arst_n,
	rict_if.sink   req,
	rict_if.source rsp
);
	logic                 out_free, out_load;
	logic [1:0]           out_sel;
	rict_pkg::rict_cmd_t  cmd;
	rict_pkg::rict_sts_t  sts;

	logic [2:0]            r_status;
	logic [AGENT_BITS-1:0] r_other;
	logic                  r_found;
	logic [rict_pkg::LEN_BITS-1:0] r_len;
	logic [rict_pkg::CNT_BITS-1:0] r_removed;
	logic                  r_last;
	logic                  out_valid_q;

	rict_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_op    (req.data.op),
		.in_ready (req.ready),
		.out_free (out_free),
		.out_load (out_load),
		.out_sel  (out_sel),
		.cmd      (cmd),
		.sts      (sts)
	);

	rict_dpath #(
		.MAX_CLAIMS (MAX_CLAIMS),
		.AGENT_BITS (AGENT_BITS),
		.INDEX_BITS (INDEX_BITS),
		.POS_BITS   (POS_BITS),
		.RANK_BITS  (RANK_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_op       (req.data.op),
		.in_agent    (AGENT_BITS'(req.data.agent_id)),
		.in_kind     (req.data.res_kind),
		.in_index    (INDEX_BITS'(req.data.res_index)),
		.in_from     (POS_BITS'(req.data.pos_from)),
		.in_to       (POS_BITS'(req.data.pos_to)),
		.in_occ      (req.data.is_occupied),
		.in_rank     (RANK_BITS'(req.data.rank)),
		.cmd         (cmd),
		.sts         (sts),
		.out_sel     (out_sel),
		.res_status  (r_status),
		.res_other   (r_other),
		.res_found   (r_found),
		.res_len     (r_len),
		.res_removed (r_removed),
		.res_last    (r_last)
	);

	assign out_free  = !out_valid_q || rsp.ready;
	assign rsp.valid = out_valid_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp.data.status        <= r_status;
			rsp.data.other_agent   <= 16'(r_other);
			rsp.data.found         <= r_found;
			rsp.data.length_sum    <= r_len;
			rsp.data.removed_count <= r_removed;
			rsp.data.last          <= r_last;
		end
	end

	// the output register never takes a result while one is stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |-> !out_load)
		else $error("result overwritten while stalled");

	// no new item while a notice waits in the output register
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data.last |-> !req.ready)
		else $error("item accepted with notices pending");

	// a notice is never the final word of an item
	a_notice_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == rict_pkg::ST_NOTICE |-> !rsp.data.last)
		else $error("notice marked last");
endmodule

### dv/rict_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rict_tb_pkg: channel payloads for the claim table testbench
// Request and response bundles carried by the valid/ready channels.
// ----------------------------------------------------------------------------
package rict_tb_pkg;

	typedef struct packed {
		logic [3:0]  op;
		logic [15:0] agent_id;
		logic [1:0]  res_kind;
		logic [15:0] res_index;
		logic [23:0] pos_from;
		logic [23:0] pos_to;
		logic        is_occupied;
		logic [7:0]  rank;
	} rict_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] other_agent;
		logic        found;
		logic [29:0] length_sum;
		logic [6:0]  removed_count;
		logic        last;
	} rict_rsp_t;

endpackage

### dv/rict_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rict_table_checker: claim table predictor and response scoreboard
// Mirrors the table on every request transfer, queues the expected results
// and compares each response transfer with the oldest one, field by field.
// ----------------------------------------------------------------------------
module rict_table_checker
	import rict_pkg::*;
	import rict_tb_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  rict_req_t req_data,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  rict_rsp_t rsp_data,
	output int        fail_count,
	output int        pending,
	output int        checked
);

	logic        slot_used  [SLOTS];
	logic [15:0] slot_agent [SLOTS];
	logic [1:0]  slot_kind  [SLOTS];
	logic [15:0] slot_res   [SLOTS];
	logic [23:0] slot_start [SLOTS];
	logic [23:0] slot_end   [SLOTS];
	logic        slot_occ   [SLOTS];
	logic [7:0]  slot_rank  [SLOTS];

	rict_rsp_t expected_q[$];

	assign pending = expected_q.size();

	function automatic rict_rsp_t make_result(logic [2:0] st, logic [15:0] other,
			logic fnd, logic [29:0] len, int unsigned removed, logic lst);
		rict_rsp_t r;
		r.status        = st;
		r.other_agent   = other;
		r.found         = fnd;
		r.length_sum    = len;
		r.removed_count = (removed > 127) ? 7'd127 : removed[6:0];
		r.last          = lst;
		return r;
	endfunction

	// update the mirrored table and queue the results of one request
	task automatic apply_request(rict_req_t q);
		int          own;
		int          hit;
		bit          mark [SLOTS];
		bit          blocked;
		bit          drop;
		logic [15:0] blocker;
		int unsigned removed;
		longint unsigned sum;
		own     = -1;
		hit     = -1;
		blocked = 0;
		blocker = '0;
		removed = 0;
		sum     = 0;
		for (int i = 0; i < SLOTS; i++) mark[i] = 0;
		case (q.op)
			OP_CLAIM: begin
				// find own slot, lowest blocker and reservations to evict
				for (int i = 0; i < SLOTS; i++) begin
					if (blocked || !slot_used[i] || slot_kind[i] != q.res_kind ||
							slot_res[i] != q.res_index)
						continue;
					if (slot_agent[i] == q.agent_id) begin
						if (own < 0) own = i;
					end else if (q.res_kind != KIND_EDGE ||
							(q.pos_from < slot_end[i] && slot_start[i] < q.pos_to)) begin
						if (slot_occ[i] || (!q.is_occupied && slot_rank[i] >= q.rank)) begin
							blocked = 1;
							blocker = slot_agent[i];
						end else begin
							mark[i] = 1;
						end
					end
				end
				if (blocked) begin
					expected_q.push_back(make_result(ST_HELD, blocker, 0, 0, 0, 1));
				end else begin
					if (own < 0)
						for (int i = 0; i < SLOTS; i++)
							if (!slot_used[i]) begin
								own = i;
								break;
							end
					if (own < 0) begin
						expected_q.push_back(make_result(ST_FULL, 0, 0, 0, 0, 1));
					end else begin
						slot_used[own]  = 1;
						slot_agent[own] = q.agent_id;
						slot_kind[own]  = q.res_kind;
						slot_res[own]   = q.res_index;
						slot_start[own] = q.pos_from;
						slot_end[own]   = q.pos_to;
						slot_occ[own]   = q.is_occupied;
						slot_rank[own]  = q.rank;
						for (int i = 0; i < SLOTS; i++)
							if (mark[i]) begin
								expected_q.push_back(make_result(ST_NOTICE, slot_agent[i],
									0, 0, 0, 0));
								slot_used[i] = 0;
							end
						expected_q.push_back(make_result(ST_GRANTED, 0, 0, 0, 0, 1));
					end
				end
			end
			OP_REL_RES, OP_REL_ALL, OP_REL_RSV, OP_REL_AGT_GL, OP_REL_ALL_GL,
			OP_CLEAR: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!slot_used[i]) continue;
					case (q.op)
						OP_REL_RES:    drop = slot_agent[i] == q.agent_id &&
							slot_kind[i] == q.res_kind && slot_res[i] == q.res_index;
						OP_REL_ALL:    drop = slot_agent[i] == q.agent_id;
						OP_REL_RSV:    drop = slot_agent[i] == q.agent_id && !slot_occ[i];
						OP_REL_AGT_GL: drop = slot_agent[i] == q.agent_id &&
							(slot_kind[i] == KIND_EDGE || slot_kind[i] == KIND_NODE);
						OP_REL_ALL_GL: drop = slot_kind[i] == KIND_EDGE ||
							slot_kind[i] == KIND_NODE;
						default:       drop = 1;
					endcase
					if (drop) begin
						slot_used[i] = 0;
						removed++;
					end
				end
				expected_q.push_back(make_result(ST_RELEASE, 0, 0, 0, removed, 1));
			end
			OP_HELD: begin
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && slot_used[i] && slot_kind[i] == q.res_kind &&
							slot_res[i] == q.res_index && slot_agent[i] != q.agent_id)
						hit = i;
				if (hit >= 0)
					expected_q.push_back(make_result(ST_ANSWER, slot_agent[hit], 1, 0, 0, 1));
				else
					expected_q.push_back(make_result(ST_ANSWER, 0, 0, 0, 0, 1));
			end
			OP_LENGTH: begin
				for (int i = 0; i < SLOTS; i++)
					if (slot_used[i] && slot_kind[i] == KIND_EDGE &&
							slot_res[i] == q.res_index && slot_agent[i] != q.agent_id &&
							slot_end[i] > slot_start[i])
						sum += slot_end[i] - slot_start[i];
				if (sum > 64'h3FFF_FFFF) sum = 64'h3FFF_FFFF;
				expected_q.push_back(make_result(ST_ANSWER, 0, 0, sum[29:0], 0, 1));
			end
			default: begin
				// unknown codes leave the table alone and answer nothing
			end
		endcase
	endtask

	task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// predict on request transfers, score response transfers
	always @(posedge clk or negedge arst_n) begin
		rict_rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) slot_used[i] = 0;
			expected_q.delete();
			fail_count = 0;
			checked    = 0;
		end else begin
			if (req_valid && req_ready)
				apply_request(req_data);
			if (rsp_valid && rsp_ready) begin
				checked++;
				if (expected_q.size() == 0) begin
					$error("response with nothing expected: status 0x%0h", rsp_data.status);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					compare_field("status", want.status, rsp_data.status);
					compare_field("other_agent", want.other_agent, rsp_data.other_agent);
					compare_field("found", want.found, rsp_data.found);
					compare_field("length_sum", want.length_sum, rsp_data.length_sum);
					compare_field("removed_count", want.removed_count, rsp_data.removed_count);
					compare_field("last", want.last, rsp_data.last);
				end
			end
		end
	end

endmodule

### dv/ranked_interval_claim_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ranked_interval_claim_table_unit_tb: claim table testbench top
// Drives directed and random operations with random gaps and response
// stalls; the checker beside the block predicts and scores every result.
// ----------------------------------------------------------------------------
module ranked_interval_claim_table_unit_tb;
	import rict_pkg::*;
	import rict_tb_pkg::*;

	localparam int RANDOM_ITEMS = 300;
	localparam int IDLE_LIMIT   = 20000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   checked;
	int   sent;
	int   claims;
	int   idle_cycles;
	int   stall_left;

	rict_if #(.payload_t(rict_req_t)) req_ch ();
	rict_if #(.payload_t(rict_rsp_t)) rsp_ch ();

	ranked_interval_claim_table_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	rict_table_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_ch.valid),
		.req_ready  (req_ch.ready),
		.req_data   (req_ch.data),
		.rsp_valid  (rsp_ch.valid),
		.rsp_ready  (rsp_ch.ready),
		.rsp_data   (rsp_ch.data),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// mostly short gaps, now and then a long one, often none
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// stall the response side in stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= 0;
		end else if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= pick_gap();
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// present one request after a random gap and hold it until the transfer
	task automatic send(rict_req_t q);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= q;
		do @(posedge clk); while (!req_ch.ready);
		sent++;
		if (q.op == OP_CLAIM) claims++;
	endtask

	task automatic send_fields(logic [3:0] op, logic [15:0] agent, logic [1:0] kind,
			logic [15:0] idx, logic [23:0] from, logic [23:0] to, logic occ, logic [7:0] rank);
		rict_req_t q;
		q.op = op; q.agent_id = agent; q.res_kind = kind; q.res_index = idx;
		q.pos_from = from; q.pos_to = to; q.is_occupied = occ; q.rank = rank;
		send(q);
	endtask

	// random request: small pools so claims collide, with full-range noise
	function automatic rict_req_t random_request();
		rict_req_t q;
		int r;
		r = $urandom_range(0, 99);
		if (r < 58)      q.op = OP_CLAIM;
		else if (r < 61) q.op = OP_REL_RES;
		else if (r < 64) q.op = OP_REL_ALL;
		else if (r < 67) q.op = OP_REL_RSV;
		else if (r < 70) q.op = OP_REL_AGT_GL;
		else if (r < 72) q.op = OP_REL_ALL_GL;
		else if (r < 83) q.op = OP_HELD;
		else if (r < 94) q.op = OP_LENGTH;
		else if (r < 96) q.op = OP_CLEAR;
		else             q.op = 4'($urandom_range(9, 15));
		q.agent_id  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
		q.res_index = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
		r = $urandom_range(0, 9);
		q.res_kind  = (r < 6) ? KIND_EDGE : 2'($urandom_range(1, 3));
		if ($urandom_range(0, 9) == 0) begin
			q.pos_from = 24'($urandom);
			q.pos_to   = 24'($urandom);
		end else begin
			q.pos_from = 24'($urandom_range(0, 15) << 8) | 24'($urandom_range(0, 255));
			q.pos_to   = q.pos_from + 24'($urandom_range(1, 1024));
			if ($urandom_range(0, 19) == 0) q.pos_to = q.pos_from - 24'($urandom_range(0, 4));
		end
		q.is_occupied = ($urandom_range(0, 3) == 0);
		q.rank        = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
		return q;
	endfunction

	initial begin
		rict_req_t q;
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		sent         = 0;
		claims       = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every operation, the special cases
		send_fields(OP_CLAIM, 16'hFFFF, KIND_EDGE, 16'hFFFF, 24'h0, 24'hFFFFFF, 0, 8'hFF);
		send_fields(OP_CLAIM, 16'h0000, KIND_EDGE, 16'hFFFF, 24'h10, 24'h20, 0, 8'h00);
		send_fields(OP_LENGTH, 16'h0000, KIND_EDGE, 16'hFFFF, 24'h0, 24'h0, 0, 8'h0);
		send_fields(OP_CLAIM, 16'h0001, KIND_EDGE, 16'hFFFF, 24'h100, 24'h200, 1, 8'h00);
		send_fields(OP_CLAIM, 16'h0002, KIND_EDGE, 16'hFFFF, 24'h200, 24'h300, 0, 8'h05);
		send_fields(OP_CLAIM, 16'h0003, KIND_EDGE, 16'hFFFF, 24'h400, 24'h380, 0, 8'h01);
		send_fields(OP_CLAIM, 16'h0003, KIND_EDGE, 16'hFFFF, 24'h180, 24'h280, 0, 8'h09);
		send_fields(OP_CLAIM, 16'h0004, KIND_NODE, 16'h0007, 24'h0, 24'h0, 0, 8'h03);
		send_fields(OP_CLAIM, 16'h0005, KIND_NODE, 16'h0007, 24'h0, 24'h0, 0, 8'h03);
		send_fields(OP_CLAIM, 16'h0005, KIND_NODE, 16'h0007, 24'h0, 24'h0, 1, 8'h04);
		send_fields(OP_CLAIM, 16'h0004, KIND_NODE, 16'h0007, 24'h0, 24'h0, 0, 8'h04);
		send_fields(OP_CLAIM, 16'h0006, 2'd2, 16'h0001, 24'h0, 24'h0, 0, 8'h02);
		send_fields(OP_CLAIM, 16'h0006, 2'd3, 16'h0001, 24'h0, 24'h0, 0, 8'h02);
		send_fields(OP_HELD, 16'h0006, 2'd3, 16'h0001, 24'h0, 24'h0, 0, 8'h0);
		send_fields(OP_HELD, 16'h0009, KIND_NODE, 16'h0007, 24'h0, 24'h0, 0, 8'h0);
		send_fields(OP_REL_RSV, 16'h0006, KIND_EDGE, 16'h0, 24'h0, 24'h0, 0, 8'h0);
		send_fields(OP_REL_AGT_GL, 16'h0005, KIND_EDGE, 16'h0, 24'h0, 24'h0, 0, 8'h0);
		send_fields(OP_REL_RES, 16'h0003, KIND_EDGE, 16'hFFFF, 24'h0, 24'h0, 0, 8'h0);
		send_fields(4'd15, 16'h0003, KIND_EDGE, 16'hFFFF, 24'h0, 24'h0, 0, 8'h0);
		send_fields(OP_REL_ALL, 16'h0001, KIND_EDGE, 16'h0, 24'h0, 24'h0, 0, 8'h0);
		send_fields(OP_REL_ALL_GL, 16'h0000, KIND_EDGE, 16'h0, 24'h0, 24'h0, 0, 8'h0);
		send_fields(OP_CLEAR, 16'h0000, KIND_EDGE, 16'h0, 24'h0, 24'h0, 0, 8'h0);

		// random: mostly colliding claims, sometimes a burst of 24 node claims
		while (sent < RANDOM_ITEMS + 22) begin
			if ($urandom_range(0, 24) == 0) begin
				for (int k = 0; k < 24; k++)
					send_fields(OP_CLAIM, 16'($urandom_range(7, 9)), KIND_NODE,
						16'($urandom_range(100, 140)), 24'h0, 24'h0, 0, 8'($urandom));
			end else begin
				q = random_request();
				send(q);
			end
		end
		req_ch.valid <= 1'b0;

		wait (pending == 0);
		repeat (200) @(posedge clk);
		$display("Sent %0d requests (%0d claims); checked %0d responses under random stalls.",
			sent, claims, checked);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/rict_pkg.sv
hw/rtl/rict_if.sv
hw/rtl/rict_ram.sv
hw/rtl/rict_ctrl.sv
hw/rtl/rict_dpath.sv
hw/rtl/ranked_interval_claim_table_unit.sv
dv/rict_tb_pkg.sv
dv/rict_table_checker.sv
dv/ranked_interval_claim_table_unit_tb.sv
